/* src/lpgt_pkg.sv */
// ----------------------------------------------------------------------------
// lpgt_pkg
// Shared codes and constants for the linear-probe guard table.
// ----------------------------------------------------------------------------
package lpgt_pkg;

  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_MODIFY = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CHECK  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY = 2'd0,
    KIND_USED  = 2'd1,
    KIND_TOMB  = 2'd2
  } kind_e;

endpackage

/* src/lpgt_if.sv */
// ----------------------------------------------------------------------------
// lpgt_req_if / lpgt_rsp_if
// Valid/ready channels for table requests and responses.
// ----------------------------------------------------------------------------
interface lpgt_req_if #(
  parameter int unsigned KEY_WIDTH  = 16,
  parameter int unsigned FLAG_WIDTH = 8
);
  logic                          valid;
  logic                          ready;
  logic [lpgt_pkg::ACTION_W-1:0] action;
  logic [KEY_WIDTH-1:0]          key;
  logic [FLAG_WIDTH-1:0]         flag_bits;

  modport source (output valid, action, key, flag_bits, input ready);
  modport sink   (input valid, action, key, flag_bits, output ready);
endinterface

interface lpgt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpgt_pkg::STATUS_W-1:0] status;
  logic                          hit;
  logic [lpgt_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, status, hit, slot, input ready);
  modport sink   (input valid, status, hit, slot, output ready);
endinterface

/* src/linear_probe_guard_table_unit.sv */
// Flow: an accepted item probes P slots, P = 1..TABLE_DEPTH; when TABLE_DEPTH is not a power of two,
//   the reciprocal hashing phases PH_LOW, PH_HIGH and PH_DONE run before the walk.
// Throughput: one item at a time; the probe walk reads one slot per cycle through the
//   single read port of the slot memory.
// Reset: a clearing pass marks every slot empty; no request is accepted until it finishes.
// ----------------------------------------------------------------------------
// linear_probe_guard_table_unit
// Open-addressed hash table with linear probing and tombstones, held in one
// synchronous memory and walked one slot per cycle.
// ----------------------------------------------------------------------------
module linear_probe_guard_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 16,
  parameter int unsigned FLAG_WIDTH  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpgt_req_if.sink  req,
  lpgt_rsp_if.source rsp
);
  import lpgt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = KIND_W + KEY_WIDTH + FLAG_WIDTH;
  localparam int unsigned SH = KEY_WIDTH + AW;
  localparam int unsigned PW = 65;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] DEPTH_LO = AW'(TABLE_DEPTH);
  localparam logic [63:0]   RECIP_W  =
    ((64'd1 << SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [32:0]   RECIP    = RECIP_W[32:0];
  localparam bit            POW2     = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [EW-1:0] mem [TABLE_DEPTH];

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic [1:0]            ph_q, ph_d;
  logic [PW-1:0]         acc_q, acc_d;
  logic                  free_vld_q, free_vld_d;
  logic [AW-1:0]         free_idx_q, free_idx_d;
  logic [ACTION_W-1:0]   action_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [FLAG_WIDTH-1:0] flag_q;
  logic                  out_vld_q, out_vld_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  hit_q, hit_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;

  logic [EW-1:0]         rdata_q;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [EW-1:0]         wd;

  logic                  accept;
  logic [KEY_WIDTH+AW-1:0] key_ext;
  logic [AW-1:0]         home;
  logic [31:0]           key_pad;
  logic [15:0]           key_half;
  logic [48:0]           part;
  logic [AW-1:0]         quot_lo;
  logic [AW-1:0]         qd;
  logic [AW-1:0]         hash_rem;
  logic [AW-1:0]         idx_nx;
  logic [KIND_W-1:0]     r_kind;
  logic [KEY_WIDTH-1:0]  r_key;
  logic [FLAG_WIDTH-1:0] r_flag;
  logic                  r_used, r_empty, r_match;
  logic                  cand_vld;
  logic [AW-1:0]         cand_idx;
  logic                  resolve;
  logic [AW-1:0]         res_idx;
  logic [SLOT_W+AW-1:0]  slot_ext;

  assign req.ready = (state_q == S_IDLE) && (!out_vld_q || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid  = out_vld_q;
  assign rsp.status = status_q;
  assign rsp.hit    = hit_q;
  assign rsp.slot   = slot_q;

  assign key_ext = {AW'(0), req.key};
  assign home    = key_ext[AW-1:0];
  assign key_pad = 32'(key_q);

  // key mod depth by reciprocal multiply, one 16-bit half of the key per cycle
  always_comb begin
    key_half = (ph_q == PH_LOW) ? key_pad[15:0] : key_pad[31:16];
    part     = 49'(key_half) * 49'(RECIP);
    case (ph_q)
      PH_LOW: begin
        acc_d = PW'(part);
      end
      PH_HIGH: begin
        acc_d = acc_q + {part, 16'd0};
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
    quot_lo  = acc_q[SH +: AW];
    qd       = quot_lo * DEPTH_LO;
    hash_rem = key_pad[AW-1:0] - qd;
  end

  assign idx_nx  = (idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);
  assign r_kind  = rdata_q[EW-1 -: KIND_W];
  assign r_key   = rdata_q[FLAG_WIDTH +: KEY_WIDTH];
  assign r_flag  = rdata_q[FLAG_WIDTH-1:0];
  assign r_used  = (r_kind == KIND_USED);
  assign r_empty = (r_kind == KIND_EMPTY);
  assign r_match = r_used && (r_key == key_q);

  assign cand_vld = free_vld_q || !r_used;
  assign cand_idx = free_vld_q ? free_idx_q : idx_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    ph_d       = ph_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    out_vld_d  = out_vld_q;
    status_d   = status_q;
    hit_d      = hit_q;
    slot_d     = slot_q;
    rd_addr    = idx_q;
    we         = 1'b0;
    wa         = idx_q;
    wd         = '0;
    resolve    = 1'b0;
    res_idx    = '0;

    if (rsp.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = {KIND_EMPTY, KEY_WIDTH'(0), FLAG_WIDTH'(0)};
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = home;
        if (accept) begin
          cnt_d      = '0;
          free_vld_d = 1'b0;
          ph_d       = PH_LOW;
          idx_d      = home;
          state_d    = POW2 ? S_LOOK : S_HASH;
        end
      end
      S_HASH: begin
        if (ph_q == PH_DONE) begin
          rd_addr = hash_rem;
          idx_d   = hash_rem;
          state_d = S_LOOK;
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      S_LOOK: begin
        rd_addr = idx_nx;
        if (r_match || r_empty || (cnt_q == LAST_IDX)) begin
          resolve = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_nx;
          cnt_d = cnt_q + AW'(1);
          if (!free_vld_q && !r_used) begin
            free_vld_d = 1'b1;
            free_idx_d = idx_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (resolve) begin
      out_vld_d = 1'b1;
      hit_d     = 1'b0;
      status_d  = ST_OK;
      res_idx   = idx_q;
      case (action_q)
        ACT_ADD: begin
          if (r_match) begin
            status_d = ST_EXISTS;
          end else if (cand_vld) begin
            res_idx = cand_idx;
            we      = 1'b1;
            wa      = cand_idx;
            wd      = {KIND_USED, key_q, flag_q};
          end else begin
            status_d = ST_FULL;
          end
        end
        ACT_MODIFY: begin
          if (r_match) begin
            we = 1'b1;
            wd = {KIND_USED, key_q, flag_q};
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        ACT_REMOVE: begin
          if (r_match) begin
            we = 1'b1;
            wd = {KIND_TOMB, key_q, FLAG_WIDTH'(0)};
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: begin
          if (r_match) begin
            hit_d = |(r_flag & flag_q);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
      endcase
      if (status_d == ST_FULL || status_d == ST_NOT_FOUND) begin
        res_idx = '0;
      end
      slot_d = slot_ext[SLOT_W-1:0];
    end
  end

  assign slot_ext = {SLOT_W'(0), res_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      out_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      cnt_q      <= '0;
      ph_q       <= PH_LOW;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      out_vld_q  <= out_vld_d;
      free_vld_q <= free_vld_d;
      cnt_q      <= cnt_d;
      ph_q       <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    hit_q      <= hit_d;
    slot_q     <= slot_d;
    acc_q      <= acc_d;
    if (accept) begin
      action_q <= req.action;
      key_q    <= req.key;
      flag_q   <= req.flag_bits;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule

/* src/lpgt_checker.sv */
// ----------------------------------------------------------------------------
// lpgt_checker
// Port-level checks for the guard table, bound to linear_probe_guard_table_unit.
// ----------------------------------------------------------------------------
module lpgt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [lpgt_pkg::STATUS_W-1:0] rsp_status_i,
  input logic                          rsp_hit_i,
  input logic [lpgt_pkg::SLOT_W-1:0]   rsp_slot_i
);
  import lpgt_pkg::*;

  // response holds while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_hit_i) && $stable(rsp_slot_i))
    else $error("response changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second item accepted while one is in flight");

  // no response in the cycle after an accept
  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !rsp_valid_i)
    else $error("response too early or stale");

  // miss and full carry no slot and no hit
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL || rsp_status_i == ST_NOT_FOUND)
      |-> rsp_slot_i == '0 && !rsp_hit_i)
    else $error("miss response with slot or hit set");

endmodule

bind linear_probe_guard_table_unit lpgt_checker u_lpgt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_status_i (rsp.status),
  .rsp_hit_i    (rsp.hit),
  .rsp_slot_i   (rsp.slot)
);
